/* src/dvru_pkg.sv */
// Shared constants and types of the distance-vector route update block.
package dvru_pkg;

   localparam int NODE_LIMIT_DEFAULT = 8;
   localparam int COST_WIDTH_DEFAULT = 16;
   localparam int RESULT_LIMIT       = 63;
   localparam int COUNT_WIDTH        = 6;
   localparam int CSR_INDEX_WIDTH    = 1;
   localparam int CSR_DATA_WIDTH     = 4;

   localparam logic OP_LINK   = 1'b0;
   localparam logic OP_VECTOR = 1'b1;

   localparam logic KIND_ROUTE = 1'b0;
   localparam logic KIND_ADV   = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SELF_NODE  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NODE_COUNT = 1'b1;

   localparam logic [3:0] VIA_NONE = 4'hF;

   typedef struct packed {
      logic       kind;
      logic [2:0] dest;
      logic [3:0] via;
      logic [2:0] target;
      logic       last;
   } rsp_meta_type;

endpackage

/* src/dvru_ram.sv */
// Generic simple dual-port RAM with a registered read.
module dvru_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* src/dvru_engine.sv */
// Sequencer: item handling, Bellman-Ford scan, advertisement and result ordering.
module dvru_engine #(
   parameter int NODE_LIMIT = 8,
   parameter int COST_WIDTH = 16,
   parameter int NW         = $clog2(NODE_LIMIT),
   parameter int AW         = $clog2(NODE_LIMIT * NODE_LIMIT)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_fire,
   input  logic                    req_operation,
   input  logic [2:0]              req_peer_node,
   input  logic [2:0]              req_entry_index,
   input  logic [COST_WIDTH-1:0]   req_cost_value,
   input  logic                    req_last_entry,
   input  logic [NW-1:0]           me,
   input  logic [NW:0]             n,
   output logic                    busy,
   output logic                    ram_wr_en,
   output logic [AW-1:0]           ram_wr_addr,
   output logic [COST_WIDTH-1:0]   ram_wr_data,
   output logic [AW-1:0]           ram_rd_addr,
   input  logic [COST_WIDTH-1:0]   ram_rd_data,
   input  logic                    out_free,
   output logic                    emit_valid,
   output dvru_pkg::rsp_meta_type  emit_meta,
   output logic [COST_WIDTH-1:0]   emit_cost
);
   import dvru_pkg::*;

   localparam logic [COST_WIDTH-1:0] INF = {COST_WIDTH{1'b1}};

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_PREV_RD  = 4'd2;
   localparam logic [3:0] S_PREV_WR  = 4'd3;
   localparam logic [3:0] S_D_NEXT   = 4'd4;
   localparam logic [3:0] S_H_RD     = 4'd5;
   localparam logic [3:0] S_H_CMP    = 4'd6;
   localparam logic [3:0] S_STALE_RD = 4'd7;
   localparam logic [3:0] S_OLD_RD   = 4'd8;
   localparam logic [3:0] S_DEC      = 4'd9;
   localparam logic [3:0] S_ADV_H    = 4'd10;
   localparam logic [3:0] S_ADV_RD   = 4'd11;
   localparam logic [3:0] S_ADV_EM   = 4'd12;
   localparam logic [3:0] S_FLUSH    = 4'd13;

   function automatic logic [AW-1:0] cell_addr(input logic [NW-1:0] r, input logic [NW-1:0] c);
      return AW'(AW'(r) * AW'(NODE_LIMIT) + AW'(c));
   endfunction

   logic [3:0]            state_ff, state_in;
   logic                  op_ff, op_in;
   logic [NW-1:0]         peer_ff, peer_in;
   logic [NW-1:0]         entry_ff, entry_in;
   logic [COST_WIDTH-1:0] cost_ff, cost_in;
   logic                  last_ff, last_in;
   logic [COST_WIDTH-1:0] prev_ff, prev_in;
   logic [NW:0]           d_ff, d_in;
   logic [NW:0]           h_ff, h_in;
   logic [NW:0]           i_ff, i_in;
   logic [COST_WIDTH-1:0] best_ff, best_in;
   logic                  via_valid_ff, via_valid_in;
   logic [NW-1:0]         via_ff, via_in;
   logic                  stale_chk_ff, stale_chk_in;
   logic                  stale_ff, stale_in;
   logic                  changed_ff, changed_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                  pend_valid_ff, pend_valid_in;
   rsp_meta_type          pend_meta_ff, pend_meta_in;
   logic [COST_WIDTH-1:0] pend_cost_ff, pend_cost_in;
   logic [NW-1:0]         clr_r_ff, clr_r_in;
   logic [NW-1:0]         clr_c_ff, clr_c_in;

   logic [COST_WIDTH-1:0] link_ff [NODE_LIMIT];
   logic                  nh_valid_ff [NODE_LIMIT];
   logic [NW-1:0]         nh_idx_ff [NODE_LIMIT];

   logic                  link_we, nh_we;
   logic [NW-1:0]         nh_rd_idx;
   logic                  nh_rd_valid;
   logic [NW-1:0]         nh_rd_node;
   logic [COST_WIDTH:0]   sum;
   logic [COST_WIDTH-1:0] cand;
   logic                  h_live;
   logic                  emit_ok;
   logic                  produce;
   rsp_meta_type          new_meta;
   logic [COST_WIDTH-1:0] fresh_cost;
   logic [COST_WIDTH-1:0] old_cost;
   logic                  poison;

   assign nh_rd_idx   = (state_ff == S_ADV_EM) ? i_ff[NW-1:0] : via_ff;
   assign nh_rd_valid = nh_valid_ff[nh_rd_idx];
   assign nh_rd_node  = nh_idx_ff[nh_rd_idx];
   assign h_live      = (link_ff[h_ff[NW-1:0]] != INF) && (h_ff[NW-1:0] != me);
   assign sum         = {1'b0, link_ff[h_ff[NW-1:0]]} + {1'b0, ram_rd_data};
   assign cand        = sum[COST_WIDTH] ? INF : sum[COST_WIDTH-1:0];
   assign old_cost    = (d_ff[NW-1:0] == peer_ff) ? prev_ff : ram_rd_data;
   assign poison      = nh_rd_valid && (nh_rd_node == h_ff[NW-1:0]);
   // A new result pushes the held one out, so it needs a free output slot.
   assign emit_ok     = (int'(cnt_ff) >= RESULT_LIMIT) || !pend_valid_ff || out_free;
   assign busy        = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      peer_in       = peer_ff;
      entry_in      = entry_ff;
      cost_in       = cost_ff;
      last_in       = last_ff;
      prev_in       = prev_ff;
      d_in          = d_ff;
      h_in          = h_ff;
      i_in          = i_ff;
      best_in       = best_ff;
      via_valid_in  = via_valid_ff;
      via_in        = via_ff;
      stale_chk_in  = stale_chk_ff;
      stale_in      = stale_ff;
      changed_in    = changed_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_meta_in  = pend_meta_ff;
      pend_cost_in  = pend_cost_ff;
      clr_r_in      = clr_r_ff;
      clr_c_in      = clr_c_ff;
      link_we       = 1'b0;
      nh_we         = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cell_addr(me, d_ff[NW-1:0]);
      ram_wr_data   = best_ff;
      ram_rd_addr   = cell_addr(me, d_ff[NW-1:0]);
      emit_valid    = 1'b0;
      emit_meta     = pend_meta_ff;
      emit_cost     = pend_cost_ff;
      produce       = 1'b0;
      new_meta      = '0;
      fresh_cost    = best_ff;

      case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cell_addr(clr_r_ff, clr_c_ff);
            ram_wr_data = (clr_r_ff == clr_c_ff) ? '0 : INF;
            if (int'(clr_c_ff) == NODE_LIMIT - 1) begin
               clr_c_in = '0;
               clr_r_in = clr_r_ff + 1'b1;
               if (int'(clr_r_ff) == NODE_LIMIT - 1) begin
                  state_in = S_IDLE;
               end
            end else begin
               clr_c_in = clr_c_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in         = req_operation;
               peer_in       = NW'(req_peer_node);
               entry_in      = NW'(req_entry_index);
               cost_in       = req_cost_value;
               last_in       = req_last_entry;
               cnt_in        = '0;
               changed_in    = 1'b0;
               pend_valid_in = 1'b0;
               // Items naming a node outside the table are dropped silently.
               if (!(int'(req_peer_node) >= NODE_LIMIT) &&
                   !(req_operation == OP_VECTOR && int'(req_entry_index) >= NODE_LIMIT)) begin
                  state_in = S_PREV_RD;
               end
            end
         end
         S_PREV_RD: begin
            ram_rd_addr = cell_addr(me, peer_ff);
            state_in    = S_PREV_WR;
         end
         S_PREV_WR: begin
            prev_in   = ram_rd_data;
            ram_wr_en = 1'b1;
            ram_wr_data = cost_ff;
            if (op_ff == OP_LINK) begin
               link_we     = 1'b1;
               ram_wr_addr = cell_addr(me, peer_ff);
            end else begin
               ram_wr_addr = cell_addr(peer_ff, entry_ff);
            end
            d_in     = '0;
            state_in = (op_ff == OP_LINK || last_ff) ? S_D_NEXT : S_FLUSH;
         end
         S_D_NEXT: begin
            if (d_ff >= n) begin
               h_in     = '0;
               state_in = changed_ff ? S_ADV_H : S_FLUSH;
            end else if (d_ff[NW-1:0] == me) begin
               d_in = d_ff + 1'b1;
            end else begin
               best_in      = INF;
               via_valid_in = 1'b0;
               h_in         = '0;
               state_in     = S_H_RD;
            end
         end
         S_H_RD: begin
            ram_rd_addr = cell_addr(h_ff[NW-1:0], d_ff[NW-1:0]);
            if (h_ff >= n) begin
               state_in = S_STALE_RD;
            end else if (h_live) begin
               state_in = S_H_CMP;
            end else begin
               h_in = h_ff + 1'b1;
            end
         end
         S_H_CMP: begin
            if (cand < best_ff) begin
               best_in      = cand;
               via_valid_in = 1'b1;
               via_in       = h_ff[NW-1:0];
            end
            h_in     = h_ff + 1'b1;
            state_in = S_H_RD;
         end
         S_STALE_RD: begin
            ram_rd_addr  = cell_addr(me, nh_rd_node);
            stale_chk_in = via_valid_ff && nh_rd_valid;
            state_in     = S_OLD_RD;
         end
         S_OLD_RD: begin
            stale_in = stale_chk_ff && (ram_rd_data == INF);
            state_in = S_DEC;
         end
         S_DEC: begin
            if (old_cost != best_ff || stale_ff) begin
               if (emit_ok) begin
                  ram_wr_en       = 1'b1;
                  nh_we           = 1'b1;
                  produce         = 1'b1;
                  new_meta.kind   = KIND_ROUTE;
                  new_meta.dest   = 3'(d_ff);
                  new_meta.via    = via_valid_ff ? 4'(via_ff) : VIA_NONE;
                  fresh_cost      = best_ff;
                  changed_in      = 1'b1;
                  d_in            = d_ff + 1'b1;
                  state_in        = S_D_NEXT;
               end
            end else begin
               d_in     = d_ff + 1'b1;
               state_in = S_D_NEXT;
            end
         end
         S_ADV_H: begin
            if (h_ff >= n) begin
               state_in = S_FLUSH;
            end else if (h_live) begin
               i_in     = '0;
               state_in = S_ADV_RD;
            end else begin
               h_in = h_ff + 1'b1;
            end
         end
         S_ADV_RD: begin
            ram_rd_addr = cell_addr(me, i_ff[NW-1:0]);
            if (i_ff >= n) begin
               h_in     = h_ff + 1'b1;
               state_in = S_ADV_H;
            end else begin
               state_in = S_ADV_EM;
            end
         end
         S_ADV_EM: begin
            ram_rd_addr = cell_addr(me, i_ff[NW-1:0]);
            if (emit_ok) begin
               produce         = 1'b1;
               new_meta.kind   = KIND_ADV;
               new_meta.dest   = 3'(i_ff);
               new_meta.target = 3'(h_ff);
               fresh_cost      = poison ? INF : ram_rd_data;
               i_in            = i_ff + 1'b1;
               state_in        = S_ADV_RD;
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               emit_valid     = 1'b1;
               emit_meta.last = 1'b1;
               pend_valid_in  = 1'b0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The newest result is held back one step so that the final one can be flagged.
      if (produce && int'(cnt_ff) < RESULT_LIMIT) begin
         emit_valid    = pend_valid_ff;
         pend_valid_in = 1'b1;
         pend_meta_in  = new_meta;
         pend_cost_in  = fresh_cost;
         cnt_in        = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_r_ff      <= '0;
         clr_c_ff      <= '0;
         pend_valid_ff <= 1'b0;
         changed_ff    <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         clr_r_ff      <= clr_r_in;
         clr_c_ff      <= clr_c_in;
         pend_valid_ff <= pend_valid_in;
         changed_ff    <= changed_in;
         cnt_ff        <= cnt_in;
      end
      op_ff        <= op_in;
      peer_ff      <= peer_in;
      entry_ff     <= entry_in;
      cost_ff      <= cost_in;
      last_ff      <= last_in;
      prev_ff      <= prev_in;
      d_ff         <= d_in;
      h_ff         <= h_in;
      i_ff         <= i_in;
      best_ff      <= best_in;
      via_valid_ff <= via_valid_in;
      via_ff       <= via_in;
      stale_chk_ff <= stale_chk_in;
      stale_ff     <= stale_in;
      pend_meta_ff <= pend_meta_in;
      pend_cost_ff <= pend_cost_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NODE_LIMIT; k++) begin
            link_ff[k]     <= INF;
            nh_valid_ff[k] <= 1'b0;
            nh_idx_ff[k]   <= '0;
         end
      end else begin
         if (link_we) begin
            link_ff[peer_ff] <= cost_ff;
         end
         if (nh_we) begin
            nh_valid_ff[d_ff[NW-1:0]] <= via_valid_ff;
            nh_idx_ff[d_ff[NW-1:0]]   <= via_ff;
         end
      end
   end
endmodule

/* src/distance_vector_route_update.sv */
// Top level of the distance-vector route update block.
// Each item is handled on its own: no new item is taken until the block is done with the
// last. A plain vector entry only stores its cost. A link change or a final vector entry
// starts a recomputation paced by the single read port of the cost matrix memory: for each
// destination other than this router every node in use is read and every live neighbour is
// compared, then the next hop is checked for a stale route and the entry updated if needed.
// If any route changed, each live neighbour then receives its advertisement, one read and one
// result per entry; the result side can stall any of this. After reset the cost matrix is
// cleared, during which req_stall is high. Results leave through an output register, and the
// last result of an item carries last_result.
module distance_vector_route_update #(
   parameter int NODE_LIMIT = dvru_pkg::NODE_LIMIT_DEFAULT,
   parameter int COST_WIDTH = dvru_pkg::COST_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_operation,
   input  logic [2:0]                            req_peer_node,
   input  logic [2:0]                            req_entry_index,
   input  logic [COST_WIDTH-1:0]                 req_cost_value,
   input  logic                                  req_last_entry,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_result_kind,
   output logic [2:0]                            rsp_dest_node,
   output logic signed [3:0]                     rsp_via_node,
   output logic [COST_WIDTH-1:0]                 rsp_route_cost,
   output logic [2:0]                            rsp_target_neighbour,
   output logic                                  rsp_last_result,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dvru_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [dvru_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import dvru_pkg::*;

   localparam int NW = $clog2(NODE_LIMIT);
   localparam int AW = $clog2(NODE_LIMIT * NODE_LIMIT);

   logic [2:0]            self_ff;
   logic [3:0]            count_ff;
   logic [NW-1:0]         me;
   logic [NW:0]           n;
   logic                  busy;
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
   logic [COST_WIDTH-1:0] ram_wr_data, ram_rd_data;
   logic                  out_free;
   logic                  emit_valid;
   rsp_meta_type          emit_meta;
   logic [COST_WIDTH-1:0] emit_cost;
   logic                  rsp_valid_ff;
   rsp_meta_type          rsp_meta_ff;
   logic [COST_WIDTH-1:0] rsp_cost_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         self_ff  <= 3'd0;
         count_ff <= 4'd8;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SELF_NODE:  self_ff  <= csr_data[2:0];
            CSR_NODE_COUNT: count_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   assign me = (int'(self_ff) < NODE_LIMIT) ? NW'(self_ff) : NW'(NODE_LIMIT - 1);
   assign n  = (count_ff == 4'd0)             ? (NW+1)'(1) :
               (int'(count_ff) > NODE_LIMIT)  ? (NW+1)'(NODE_LIMIT) : (NW+1)'(count_ff);

   assign req_stall = busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   dvru_ram #(
      .WIDTH(COST_WIDTH),
      .DEPTH(NODE_LIMIT * NODE_LIMIT)
   ) u_cost_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   dvru_engine #(
      .NODE_LIMIT(NODE_LIMIT),
      .COST_WIDTH(COST_WIDTH)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .req_fire        (req_valid && !req_stall),
      .req_operation   (req_operation),
      .req_peer_node   (req_peer_node),
      .req_entry_index (req_entry_index),
      .req_cost_value  (req_cost_value),
      .req_last_entry  (req_last_entry),
      .me              (me),
      .n               (n),
      .busy            (busy),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .out_free        (out_free),
      .emit_valid      (emit_valid),
      .emit_meta       (emit_meta),
      .emit_cost       (emit_cost)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit_valid) begin
         rsp_meta_ff <= emit_meta;
         rsp_cost_ff <= emit_cost;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_kind      = rsp_meta_ff.kind;
   assign rsp_dest_node        = rsp_meta_ff.dest;
   assign rsp_via_node         = rsp_meta_ff.via;
   assign rsp_route_cost       = rsp_cost_ff;
   assign rsp_target_neighbour = rsp_meta_ff.target;
   assign rsp_last_result      = rsp_meta_ff.last;
endmodule

/* src/dvru_checker.sv */
// Port-level checks of the route update block, bound to its top level.
module dvru_checker #(
   parameter int COST_WIDTH = dvru_pkg::COST_WIDTH_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_result_kind,
   input logic signed [3:0]     rsp_via_node,
   input logic [COST_WIDTH-1:0] rsp_route_cost,
   input logic [2:0]            rsp_target_neighbour
);
   import dvru_pkg::*;

   // The cost matrix is being cleared straight after reset.
   a_clear_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("no stall while the cost matrix is cleared");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   a_adv_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_ADV |-> rsp_via_node == 4'sd0)
      else $error("advertisement item carries a next hop");

   a_route_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_ROUTE |-> rsp_target_neighbour == 3'd0)
      else $error("route update item carries a target neighbour");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_route_cost))
      else $error("stalled result item changed");
endmodule

bind distance_vector_route_update dvru_checker #(.COST_WIDTH(COST_WIDTH)) u_dvru_checker (
   .clock                (clock),
   .reset                (reset),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_result_kind      (rsp_result_kind),
   .rsp_via_node         (rsp_via_node),
   .rsp_route_cost       (rsp_route_cost),
   .rsp_target_neighbour (rsp_target_neighbour)
);

/* tb/sv/tb.sv */
// Self-checking testbench of the distance-vector route update block.
module tb;
   import dvru_pkg::*;

   localparam logic [15:0] COST_INF    = 16'hFFFF;
   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          DRAIN_WAIT  = 400;

   typedef struct {
      logic        op;
      logic [2:0]  peer;
      logic [2:0]  entry;
      logic [15:0] cost;
      logic        last;
   } route_req_type;

   typedef struct {
      logic              kind;
      logic [2:0]        dest;
      logic signed [3:0] via;
      logic [15:0]       cost;
      logic [2:0]        target;
      logic              last;
   } route_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_operation = 1'b0;
   logic [2:0] req_peer_node = '0;
   logic [2:0] req_entry_index = '0;
   logic [15:0] req_cost_value = '0;
   logic req_last_entry = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_result_kind;
   logic [2:0] rsp_dest_node;
   logic signed [3:0] rsp_via_node;
   logic [15:0] rsp_route_cost;
   logic [2:0] rsp_target_neighbour;
   logic rsp_last_result;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   route_req_type pending_items[$];
   route_rsp_type expected_routes[$];

   // Predictor state.
   logic [15:0] cost_tbl[8][8];
   int          hop_tbl[8];
   logic [15:0] link_tbl[8];
   logic [2:0]  self_reg;
   logic [3:0]  count_reg;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int accepted_items = 0;
   int checked_results = 0;
   int cycle_count = 0;

   distance_vector_route_update i_dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [15:0] sat_sum(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? COST_INF : s[15:0];
   endfunction

   function automatic void push_route(logic kind, int dest, int via, logic [15:0] cost,
                                      int target);
      route_rsp_type r;
      r.kind = kind;
      r.dest = dest[2:0];
      r.via = via[3:0];
      r.cost = cost;
      r.target = target[2:0];
      r.last = 1'b0;
      expected_routes.push_back(r);
   endfunction

   function automatic void recompute_routes(int me, int n, int peer, logic [15:0] prev);
      logic        changed;
      logic [15:0] best, c, old;
      int          via, nn;
      logic        stale;
      changed = 1'b0;
      for (int d = 0; d < n; d++) begin
         if (d == me) continue;
         best = COST_INF;
         via = -1;
         stale = 1'b0;
         for (int h = 0; h < n; h++) begin
            if (link_tbl[h] < COST_INF && h != me) begin
               c = sat_sum(link_tbl[h], cost_tbl[h][d]);
               if (c < best) begin
                  best = c;
                  via = h;
               end
            end
         end
         // A next hop whose own next hop is unknown never forces an update.
         if (via >= 0) begin
            nn = hop_tbl[via];
            if (nn >= 0 && nn < 8 && cost_tbl[me][nn] == COST_INF) stale = 1'b1;
         end
         old = (d == peer) ? prev : cost_tbl[me][d];
         if (old != best || stale) begin
            hop_tbl[d] = via;
            cost_tbl[me][d] = best;
            push_route(KIND_ROUTE, d, via, best, 0);
            changed = 1'b1;
         end
      end
      if (!changed) return;
      for (int h = 0; h < n; h++) begin
         if (link_tbl[h] < COST_INF && h != me) begin
            for (int i = 0; i < n; i++)
               push_route(KIND_ADV, i, 0, (hop_tbl[i] == h) ? COST_INF : cost_tbl[me][i], h);
         end
      end
   endfunction

   function automatic void predict_routes(route_req_type it);
      int          me, n, start;
      logic [15:0] prev;
      me = self_reg;
      n = count_reg;
      if (n < 1) n = 1;
      if (n > 8) n = 8;
      start = expected_routes.size();
      prev = cost_tbl[me][it.peer];
      if (it.op == OP_LINK) begin
         link_tbl[it.peer] = it.cost;
         cost_tbl[me][it.peer] = it.cost;
         recompute_routes(me, n, it.peer, prev);
      end else begin
         cost_tbl[it.peer][it.entry] = it.cost;
         if (it.last) recompute_routes(me, n, it.peer, prev);
      end
      if (expected_routes.size() > start)
         expected_routes[expected_routes.size()-1].last = 1'b1;
   endfunction

   // Driver: present the next pending item once the current one has gone.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            route_req_type cur;
            cur.op = req_operation;
            cur.peer = req_peer_node;
            cur.entry = req_entry_index;
            cur.cost = req_cost_value;
            cur.last = req_last_entry;
            predict_routes(cur);
            accepted_items++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               route_req_type nxt;
               nxt = pending_items.pop_front();
               req_valid <= 1'b1;
               req_operation <= nxt.op;
               req_peer_node <= nxt.peer;
               req_entry_index <= nxt.entry;
               req_cost_value <= nxt.cost;
               req_last_entry <= nxt.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_routes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result: kind %0d dest %0d cost %0d", rsp_result_kind,
                           rsp_dest_node, rsp_route_cost);
            end else begin
               route_rsp_type e;
               e = expected_routes.pop_front();
               checked_results++;
               if (e.kind !== rsp_result_kind || e.dest !== rsp_dest_node ||
                   e.via !== rsp_via_node || e.cost !== rsp_route_cost ||
                   e.target !== rsp_target_neighbour || e.last !== rsp_last_result) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"Mismatch: exp k%0d d%0d v%0d c%0d t%0d l%0d",
                               " got k%0d d%0d v%0d c%0d t%0d l%0d"},
                              e.kind, e.dest, e.via, e.cost, e.target, e.last,
                              rsp_result_kind, rsp_dest_node, rsp_via_node, rsp_route_cost,
                              rsp_target_neighbour, rsp_last_result);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic write_register(logic [CSR_INDEX_WIDTH-1:0] idx, logic [3:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SELF_NODE) self_reg = val[2:0];
      else count_reg = val;
   endtask

   task automatic add_item(logic op, int peer, int entry, logic [15:0] cost, logic last);
      route_req_type it;
      it.op = op;
      it.peer = peer[2:0];
      it.entry = entry[2:0];
      it.cost = cost;
      it.last = last;
      pending_items.push_back(it);
   endtask

   function automatic logic [15:0] pick_cost();
      case ($urandom_range(3))
         0: return COST_INF;
         1: return 16'd0;
         2: return 16'($urandom_range(1, 20));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_random_items(int amount);
      int added, peer, len;
      added = 0;
      while (added < amount) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
               // A whole vector from one sender, in order, last flag on the final entry.
               peer = $urandom_range(7);
               len = $urandom_range(1, 8);
               for (int e = 0; e < len; e++)
                  add_item(OP_VECTOR, peer, e, pick_cost(), e == len - 1);
               added += len;
            end
            5, 6, 7: begin
               add_item(OP_LINK, $urandom_range(7), $urandom_range(7), pick_cost(),
                        $urandom_range(1));
               added++;
            end
            default: begin
               add_item($urandom_range(1), $urandom_range(7), $urandom_range(7),
                        16'($urandom), $urandom_range(1));
               added++;
            end
         endcase
      end
   endtask

   task automatic drain_block();
      while (pending_items.size() > 0 || req_valid || expected_routes.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   initial begin
      int selfs[5];
      int counts[5];
      int sends[5];
      int stalls[5];
      selfs = '{0, 7, 3, 5, 2};
      counts = '{8, 1, 0, 15, 5};
      sends = '{0, 56, 0, 10, 56};
      stalls = '{0, 0, 56, 10, 56};
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < 8; j++) cost_tbl[i][j] = (i == j) ? 16'd0 : COST_INF;
         hop_tbl[i] = -1;
         link_tbl[i] = COST_INF;
      end
      self_reg = 3'd0;
      count_reg = 4'd8;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 5; p++) begin
         send_idle_pct = sends[p];
         stall_pct = stalls[p];
         write_register(CSR_SELF_NODE, {1'($urandom_range(1)), 3'(selfs[p])});
         write_register(CSR_NODE_COUNT, 4'(counts[p]));
         if (p == 0) begin
            add_item(OP_LINK, 1, 7, 16'd0, 1'b1);
            add_item(OP_LINK, 2, 0, 16'd5, 1'b0);
            add_item(OP_LINK, 3, 0, 16'hFFFE, 1'b0);
            for (int e = 0; e < 8; e++)
               add_item(OP_VECTOR, 1, e, (e == 3) ? 16'hFFFE : 16'(e * 3), e == 7);
            add_item(OP_VECTOR, 0, 4, 16'd2, 1'b1);
            add_item(OP_VECTOR, 2, 7, COST_INF, 1'b1);
            add_item(OP_VECTOR, 3, 0, 16'd1, 1'b1);
            add_item(OP_LINK, 1, 0, COST_INF, 1'b0);
            add_item(OP_LINK, 7, 3, 16'd1, 1'b0);
            add_item(OP_VECTOR, 7, 5, 16'd0, 1'b0);
            add_item(OP_LINK, 0, 0, 16'd9, 1'b0);
            add_item(OP_LINK, 1, 0, 16'd4, 1'b0);
         end
         add_random_items(26);
         drain_block();
      end
      $display("Ran %0d items over five register settings and idle patterns, %0d results checked.",
               accepted_items, checked_results);
      if (mismatches == 0 && expected_routes.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d results outstanding", mismatches,
                  expected_routes.size());
         $display("Verification failed");
      end
      $finish;
   end
endmodule

/* distance_vector_route_update.f */
src/dvru_pkg.sv
src/dvru_ram.sv
src/dvru_engine.sv
src/distance_vector_route_update.sv
src/dvru_checker.sv
tb/sv/tb.sv
